@@ design/lge_pkg.sv @@
// ----------------------------------------------------------------------------
// lge_pkg
// Shared types and constants for the life generation engine: grid size,
// address widths, operation codes, register indexes and sequencer types.
// ----------------------------------------------------------------------------
package lge_pkg;

  // Grid bounds; MAX_COLS must stay a power of two so {row, col} is the address
  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 64;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int CELLS     = MAX_ROWS * MAX_COLS;

  // Configuration register width and reset values
  localparam int SIZE_W         = 7;
  localparam int CFG_IDX_W      = 1;
  localparam logic [SIZE_W-1:0] ROWS_RESET = SIZE_W'(10);
  localparam logic [SIZE_W-1:0] COLS_RESET = SIZE_W'(10);

  // Neighbor count width (0..8)
  localparam int CNT_W = 4;

  // Operation codes
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_idx_t;

  // Control from the sequencer to the cell evaluation unit
  typedef struct packed {
    logic clear;   // drop the running count and self bit
    logic acc;     // a neighborhood bit arrives this cycle
    logic center;  // the arriving bit is the cell itself
  } eval_ctrl_t;

endpackage

@@ design/lge_ram.sv @@
// ----------------------------------------------------------------------------
// lge_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module lge_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/lge_cell_eval.sv @@
// ----------------------------------------------------------------------------
// lge_cell_eval
// Shared neighbor counter: accumulates one neighborhood bit per cycle and
// applies rule B3/S23 to the running count and the cell's own state.
// ----------------------------------------------------------------------------
module lge_cell_eval
  import lge_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  eval_ctrl_t ctrl,
  input  logic       nbr_bit,
  output logic       next_bit
);

  logic [CNT_W-1:0] count;
  logic             self_bit;
  logic [CNT_W-1:0] count_all;

  // Include the bit arriving this cycle when it is a neighbor
  assign count_all = count + {{(CNT_W-1){1'b0}}, ctrl.acc & ~ctrl.center & nbr_bit};

  // Birth on three, survival on two or three
  assign next_bit = (count_all == CNT_W'(3)) || (self_bit && (count_all == CNT_W'(2)));

  // Accumulate or drop
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      count    <= '0;
      self_bit <= 1'b0;
    end else if (ctrl.acc) begin
      if (ctrl.center) begin
        self_bit <= nbr_bit;
      end else begin
        count <= count_all;
      end
    end
  end

endmodule

@@ design/life_generation_engine_unit.sv @@
// ----------------------------------------------------------------------------
// life_generation_engine_unit
// Conway life engine (B3/S23, no wrap-around) on a one-bit grid held in RAM.
//
//  channel | direction | handshake            | payload
//  in      | into unit | in_valid / in_stall  | opcode, row, col, cell_in
//  out     | from unit | out_valid / out_stall| cell_out, done_op
//  cfg     | into unit | cfg_we               | cfg_index, cfg_data
//
// Write and no-op items go from idle straight to the finishing state; read
// items pass a read state first (registered RAM read). A step item scans
// the used area one cell at a time: 9 neighborhood reads through one RAM
// read port plus one next-state write per cell, then a copy-back pass of
// one cell per cycle. After reset a clearing pass writes all 4096 cells
// dead; in_stall stays high meanwhile, configuration writes are taken as ever.
// A stalled result holds the unit in its finishing state until taken.
// ----------------------------------------------------------------------------
module life_generation_engine_unit
  import lge_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // input items
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           opcode,
  input  logic [ROW_W-1:0]     row,
  input  logic [COL_W-1:0]     col,
  input  logic                 cell_in,
  // result items
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 cell_out,
  output logic [1:0]           done_op,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_RD    = 7'b0000100,
    S_GEN   = 7'b0001000,
    S_GWR   = 7'b0010000,
    S_COPY  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [SIZE_W-1:0] rows_in_use, cols_in_use;
  logic [SIZE_W-1:0] nr, nc;

  logic              accept;
  op_t               op_in;
  logic              in_area;
  logic              area_empty;

  logic [ADDR_W-1:0] clr_addr;
  logic [ROW_W-1:0]  gen_r;
  logic [COL_W-1:0]  gen_c;
  logic [1:0]        dr, dc;
  logic [ROW_W:0]    nbr_r;
  logic [COL_W:0]    nbr_c;
  logic              nbr_in;
  logic              last_cell;
  logic              last_nbr;

  logic              p_valid, p_center, p_in;
  logic              rd_in;
  logic              res_bit;
  op_t               op_q;

  logic              cp_wen;
  logic [ADDR_W-1:0] cp_addr;

  logic              cw_en;
  logic [ADDR_W-1:0] cw_addr;
  logic              cw_data;
  logic [ADDR_W-1:0] cr_addr;
  logic              cells_q;
  logic              nx_q;
  logic              next_bit;
  logic              step_start;
  logic              out_load;
  eval_ctrl_t        ev_ctrl;

  // Used area, saturated to the grid size
  assign nr = (rows_in_use > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : rows_in_use;
  assign nc = (cols_in_use > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : cols_in_use;
  assign area_empty = (nr == '0) || (nc == '0);

  // Input handshake
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign op_in    = op_t'(opcode);
  assign in_area  = (SIZE_W'(row) < nr) && (SIZE_W'(col) < nc);
  assign step_start = accept && (op_in == OP_STEP) && !area_empty;

  // Neighbor coordinates; minus one wraps to a value beyond any used size
  assign nbr_r  = {1'b0, gen_r} + (ROW_W+1)'(dr) - (ROW_W+1)'(1);
  assign nbr_c  = {1'b0, gen_c} + (COL_W+1)'(dc) - (COL_W+1)'(1);
  assign nbr_in = (SIZE_W'(nbr_r) < nr) && (SIZE_W'(nbr_c) < nc);
  assign last_nbr  = (dr == 2'd2) && (dc == 2'd2);
  assign last_cell = (SIZE_W'(gen_r) + SIZE_W'(1) == nr) &&
                     (SIZE_W'(gen_c) + SIZE_W'(1) == nc);

  assign out_load = (state == S_FIN) && (!out_valid || !out_stall);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= ROWS_RESET;
      cols_in_use <= COLS_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ROWS: rows_in_use <= cfg_data;
        CFG_COLS: cols_in_use <= cfg_data;
        default:  ;
      endcase
    end
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_addr == ADDR_W'(CELLS - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (op_in == OP_READ)  state_next = S_RD;
          else if (step_start)   state_next = S_GEN;
          else                   state_next = S_FIN;
        end
      end
      S_RD:   state_next = S_FIN;
      S_GEN:  if (last_nbr) state_next = S_GWR;
      S_GWR:  state_next = last_cell ? S_COPY : S_GEN;
      S_COPY: if (last_cell) state_next = S_FIN;
      S_FIN:  if (out_load) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // Sequencer state, clear sweep and read pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      p_valid  <= 1'b0;
      cp_wen   <= 1'b0;
    end else begin
      state    <= state_next;
      p_valid  <= (state == S_GEN);
      cp_wen   <= (state == S_COPY);
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
    end
  end

  // Cell and neighborhood counters
  always_ff @(posedge clk) begin
    if (step_start) begin
      gen_r <= '0;
      gen_c <= '0;
      dr    <= '0;
      dc    <= '0;
    end else if (state == S_GEN) begin
      if (dc == 2'd2) begin
        dc <= '0;
        dr <= last_nbr ? 2'd0 : dr + 2'd1;
      end else begin
        dc <= dc + 2'd1;
      end
    end else if ((state == S_GWR) || (state == S_COPY)) begin
      // advance the scan; restart at the origin after the last cell
      if (last_cell) begin
        gen_r <= '0;
        gen_c <= '0;
      end else if (SIZE_W'(gen_c) + SIZE_W'(1) == nc) begin
        gen_c <= '0;
        gen_r <= gen_r + ROW_W'(1);
      end else begin
        gen_c <= gen_c + COL_W'(1);
      end
    end
  end

  // Tags for the neighborhood read in flight and the copy write
  always_ff @(posedge clk) begin
    p_center <= (dr == 2'd1) && (dc == 2'd1);
    p_in     <= nbr_in;
    cp_addr  <= {gen_r, gen_c};
  end

  // Capture item details and the result bit
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= op_in;
      rd_in   <= in_area;
      res_bit <= 1'b0;
    end else if (state == S_RD) begin
      res_bit <= cells_q & rd_in;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      cell_out <= res_bit;
      done_op  <= op_q;
    end
  end

  // Grid write port: copy-back, clear sweep, or a write item
  always_comb begin
    cw_en   = 1'b0;
    cw_addr = cp_addr;
    cw_data = nx_q;
    if (cp_wen) begin
      cw_en = 1'b1;
    end else if (state == S_CLEAR) begin
      cw_en   = 1'b1;
      cw_addr = clr_addr;
      cw_data = 1'b0;
    end else if (accept && (op_in == OP_WRITE) && in_area) begin
      cw_en   = 1'b1;
      cw_addr = {row, col};
      cw_data = cell_in;
    end
  end

  // Grid read port: item address in idle, neighbor address while scanning
  assign cr_addr = (state == S_GEN) ? {nbr_r[ROW_W-1:0], nbr_c[COL_W-1:0]} : {row, col};

  lge_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (cw_en),
    .waddr (cw_addr),
    .wdata (cw_data),
    .raddr (cr_addr),
    .rdata (cells_q)
  );

  lge_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_next (
    .clk   (clk),
    .we    (state == S_GWR),
    .waddr ({gen_r, gen_c}),
    .wdata (next_bit),
    .raddr ({gen_r, gen_c}),
    .rdata (nx_q)
  );

  // Neighbor count and rule
  assign ev_ctrl.clear  = step_start || (state == S_GWR);
  assign ev_ctrl.acc    = p_valid;
  assign ev_ctrl.center = p_center;

  lge_cell_eval u_eval (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ev_ctrl),
    .nbr_bit  (cells_q & p_in),
    .next_bit (next_bit)
  );

  // Checks
  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN))
    else $error("result raised outside the finishing state");

  a_no_grid_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_GEN) |-> !cw_en)
    else $error("grid written during a generation scan");

  a_last_nbr_arrives: assert property (@(posedge clk) disable iff (rst)
    (state == S_GWR) |-> (p_valid && !p_center))
    else $error("cell rule evaluated without its last neighbor");

  a_step_enters_scan: assert property (@(posedge clk) disable iff (rst)
    step_start |=> (state == S_GEN))
    else $error("step item did not start a scan");

endmodule

@@ tb/life_generation_engine_unit_test.sv @@
// ----------------------------------------------------------------------------
// life_generation_engine_unit_test
// Self-checking bench for the life engine. A directed run covers field
// extremes, every operation, cells outside the used area, a zero-sized and
// an oversized area. Random phases then mix writes, reads and generation
// steps over several area sizes with varied input idling and output stalls.
// Every result is checked against a cycle-free model of the grid.
// ----------------------------------------------------------------------------
module life_generation_engine_unit_test
  import lge_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT      = 3_000_000;
  localparam int SHOW_LIMIT = 10;
  localparam int SETTLE     = 4;
  localparam int LONG_HOLD  = 300;

  typedef struct packed {
    logic alive;
    op_t  op;
  } cell_result_t;

  // Grid model: full stored grid, size registers and results still to come
  class life_tracker;
    bit             grid [MAX_ROWS][MAX_COLS];
    bit             nxt  [MAX_ROWS][MAX_COLS];
    logic [SIZE_W-1:0] rows_reg;
    logic [SIZE_W-1:0] cols_reg;
    cell_result_t   pending_results[$];
    int             failures;

    function new();
      rows_reg = ROWS_RESET;
      cols_reg = COLS_RESET;
      failures = 0;
      foreach (grid[r, c]) grid[r][c] = 1'b0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [SIZE_W-1:0] val);
      if (idx == CFG_ROWS) rows_reg = val;
      else cols_reg = val;
    endfunction

    // Saturate the used size to the grid bounds
    function int used_rows();
      return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
    endfunction

    function int used_cols();
      return (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
    endfunction

    function bit in_area(int r, int c);
      return r >= 0 && c >= 0 && r < used_rows() && c < used_cols();
    endfunction

    // Compute one B3/S23 generation over the used area, cells outside dead
    function void next_generation();
      int nr, nc, n;
      nr = used_rows();
      nc = used_cols();
      for (int r = 0; r < nr; r++) begin
        for (int c = 0; c < nc; c++) begin
          n = 0;
          for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
              if ((dr != 0 || dc != 0) && in_area(r + dr, c + dc))
                n += grid[r + dr][c + dc];
          nxt[r][c] = (n == 3) || (grid[r][c] && n == 2);
        end
      end
      for (int r = 0; r < nr; r++)
        for (int c = 0; c < nc; c++)
          grid[r][c] = nxt[r][c];
    endfunction

    // Apply one accepted item and queue the result it should produce
    function void take_item(op_t op, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                            logic v);
      cell_result_t res;
      res.alive = 1'b0;
      res.op    = op;
      case (op)
        OP_WRITE: if (in_area(r, c)) grid[r][c] = v;
        OP_READ:  res.alive = in_area(r, c) ? grid[r][c] : 1'b0;
        OP_STEP:  next_generation();
        default: ;
      endcase
      pending_results.push_back(res);
    endfunction

    // Compare a result item with the oldest one queued
    function void match_result(logic bit_val, logic [1:0] op);
      cell_result_t want;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= SHOW_LIMIT)
          $display("unexpected result item: cell_out=%0b done_op=%0d", bit_val, op);
        return;
      end
      want = pending_results.pop_front();
      if (bit_val !== want.alive || op !== want.op) begin
        failures++;
        if (failures <= SHOW_LIMIT)
          $display("mismatch: cell_out exp %0b got %0b, done_op exp %0d got %0d",
                   want.alive, bit_val, want.op, op);
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [1:0]         opcode    = OP_NOP;
  logic [ROW_W-1:0]   row       = '0;
  logic [COL_W-1:0]   col       = '0;
  logic               cell_in   = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               cell_out;
  logic [1:0]         done_op;
  logic               cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ROWS;
  logic [SIZE_W-1:0]  cfg_data  = '0;

  life_tracker tracker;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int cycle_count    = 0;

  life_generation_engine_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .row       (row),
    .col       (col),
    .cell_in   (cell_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cell_out  (cell_out),
    .done_op   (done_op),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // End the run if it hangs
  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL life_generation_engine_unit");
    $finish;
  end

  // Take result items, stall at random or for a long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) tracker.match_result(cell_out, done_op);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Offer one item after random idle cycles, hold it until accepted
  task automatic send_item(op_t op, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                           logic v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    row      <= r;
    col      <= c;
    cell_in  <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_item(op, r, c, v);
  endtask

  // Stop offering and wait until every queued result has come
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write both size registers back to back; the block must be idle
  task automatic set_size(logic [SIZE_W-1:0] nrows, logic [SIZE_W-1:0] ncols);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROWS;
    cfg_data  <= nrows;
    @(posedge clk);
    tracker.set_reg(CFG_ROWS, nrows);
    cfg_index <= CFG_COLS;
    cfg_data  <= ncols;
    @(posedge clk);
    tracker.set_reg(CFG_COLS, ncols);
    cfg_we <= 1'b0;
  endtask

  // Random mix of operations over one area size; ignored items do not count
  task automatic run_phase(int nrows, int ncols, int sidle, int rstall, int target,
                           int step_pct, int hold_at, int pause_at);
    int useful, k, pick, nr, nc;
    op_t op;
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    logic v;
    drain();
    set_size(SIZE_W'(nrows), SIZE_W'(ncols));
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    nr = tracker.used_rows();
    nc = tracker.used_cols();
    useful = 0;
    k = 0;
    while (useful < target) begin
      pick = $urandom_range(99);
      if (pick < step_pct) op = OP_STEP;
      else if (pick < step_pct + 6) op = OP_NOP;
      else if (pick < step_pct + 46) op = OP_READ;
      else op = OP_WRITE;
      if ($urandom_range(99) < 85) begin
        r = ROW_W'($urandom_range(nr - 1));
        c = COL_W'($urandom_range(nc - 1));
      end else begin
        r = ROW_W'($urandom_range(MAX_ROWS - 1));
        c = COL_W'($urandom_range(MAX_COLS - 1));
      end
      v = ($urandom_range(99) < 40);
      if (k == hold_at) hold_left = LONG_HOLD;
      if (k == pause_at) drain();
      send_item(op, r, c, v);
      if (op != OP_NOP && (op != OP_WRITE || tracker.in_area(r, c))) useful++;
      k++;
    end
  endtask

  initial begin
    tracker = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Default 10x10 area: blinker on the top edge, corner cell, outside cells
    send_item(OP_WRITE, 0, 0, 1'b1);
    send_item(OP_WRITE, 0, 1, 1'b1);
    send_item(OP_WRITE, 0, 2, 1'b1);
    send_item(OP_WRITE, 9, 9, 1'b1);
    send_item(OP_WRITE, 63, 63, 1'b1);
    send_item(OP_WRITE, 9, 10, 1'b1);
    send_item(OP_READ, 0, 1, 1'b0);
    send_item(OP_READ, 63, 63, 1'b1);
    send_item(OP_READ, 9, 9, 1'b0);
    send_item(OP_NOP, 63, 63, 1'b1);
    send_item(OP_STEP, 0, 0, 1'b0);
    send_item(OP_READ, 1, 1, 1'b0);
    send_item(OP_READ, 0, 0, 1'b0);
    send_item(OP_WRITE, 1, 1, 1'b0);
    send_item(OP_READ, 1, 1, 1'b0);

    // Oversized registers saturate to the full grid: grow a block in the corner
    drain();
    set_size('1, '1);
    send_item(OP_WRITE, 63, 63, 1'b1);
    send_item(OP_WRITE, 62, 63, 1'b1);
    send_item(OP_WRITE, 63, 62, 1'b1);
    send_item(OP_STEP, 0, 0, 1'b0);
    send_item(OP_READ, 62, 62, 1'b0);
    send_item(OP_READ, 63, 63, 1'b0);

    // Empty area: writes ignored, reads zero, step leaves the grid alone
    drain();
    set_size('0, '0);
    send_item(OP_WRITE, 0, 0, 1'b1);
    send_item(OP_READ, 0, 1, 1'b0);
    send_item(OP_STEP, 0, 0, 1'b0);
    send_item(OP_READ, 63, 63, 1'b0);

    // Random phases over assorted sizes and idling patterns
    run_phase(8, 8, 0, 0, 90, 12, -1, -1);
    run_phase(5, 12, 46, 0, 90, 12, -1, 40);
    run_phase(1, 64, 0, 46, 60, 12, -1, -1);
    run_phase(100, 1, 21, 21, 60, 12, -1, -1);
    run_phase(12, 12, 21, 21, 90, 10, 30, -1);
    run_phase(3, 3, 0, 46, 60, 15, -1, -1);
    run_phase(20, 20, 0, 0, 60, 8, -1, -1);
    run_phase(4, 4, 46, 0, 60, 15, -1, -1);
    run_phase(64, 64, 21, 21, 30, 4, -1, -1);
    run_phase(7, 5, 46, 0, 30, 12, -1, -1);

    drain();
    repeat (30) @(posedge clk);
    if (tracker.failures == 0 && tracker.outstanding() == 0) begin
      $display("PASS life_generation_engine_unit");
    end else begin
      $display("FAIL life_generation_engine_unit");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/lge_pkg.sv
design/lge_ram.sv
design/lge_cell_eval.sv
design/life_generation_engine_unit.sv
tb/life_generation_engine_unit_test.sv
